/* sv/qrspf_pkg.sv */
// Shared widths and filter constants for the QRS preprocessing filter chain.
package qrspf_pkg;

	localparam int SAMPLE_W    = 12;   // converter sample width
	localparam int IN_DATA_W   = 16;   // sample padded to whole bytes

	// Recursive low-pass
	localparam int LP_TAPS     = 12;
	localparam int LP_MID      = 6;
	localparam int LP_SHIFT    = 5;
	localparam int LP_ACC_W    = 18;
	localparam int LP_W        = LP_ACC_W - LP_SHIFT;

	// High-pass: lagged low-pass value minus mean of the last 32
	localparam int HP_TAPS     = 32;
	localparam int HP_LAG      = 15;
	localparam int HP_SHIFT    = 5;
	localparam int HP_SUM_W    = 18;
	localparam int HP_W        = 14;

	// Five-point derivative
	localparam int SLOPE_TAPS  = 4;
	localparam int SLOPE_RAW_W = 16;
	localparam int SLOPE_SHIFT = 3;
	localparam int SLOPE_W     = SLOPE_RAW_W - SLOPE_SHIFT;

	// Squaring and moving-window integration
	localparam int SQ_W        = 24;
	localparam int WIN_LEN     = 32;
	localparam int WIN_SHIFT   = $clog2(WIN_LEN);
	localparam int WIN_SUM_W   = SQ_W + WIN_SHIFT;
	localparam int ENERGY_W    = WIN_SUM_W - WIN_SHIFT;

	localparam int OUT_FIELDS_W = HP_W + SLOPE_W + ENERGY_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Pipeline depth: input register through result register
	localparam int NUM_STAGES  = 6;

	typedef logic signed [SAMPLE_W-1:0]  sample_t;
	typedef logic signed [LP_ACC_W-1:0]  lp_acc_t;
	typedef logic signed [LP_W-1:0]      lp_t;
	typedef logic signed [HP_SUM_W-1:0]  hp_sum_t;
	typedef logic signed [HP_W-1:0]      hp_t;
	typedef logic signed [SLOPE_RAW_W-1:0] slope_raw_t;
	typedef logic signed [SLOPE_W-1:0]   slope_t;
	typedef logic        [SQ_W-1:0]      sq_t;
	typedef logic        [WIN_SUM_W-1:0] win_sum_t;
	typedef logic        [ENERGY_W-1:0]  energy_t;

endpackage

/* sv/qrs_preprocess_filter_chain_core.sv */
// A sample passes the input, low-pass, high-pass, derivative, square and result registers.
// Throughput: one sample per cycle unless the output stalls; six register stages, each
// with its own valid bit, so a stalled result only holds the occupied stages behind it.
// The low-pass and running-sum recursions each close within one stage.
// Reset: arst_n clears all delay lines, recursive sums and stage valid bits.
// Top level of the QRS preprocessing chain: low-pass, high-pass, derivative, square, window.
module qrs_preprocess_filter_chain_core
	import qrspf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] ecg_sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // [13:0] band_passed, [26:14] slope_value,
	                                              // [50:27] integrated_energy, rest zero
);

	// stage valid bits, index 0 is the input register, last is the result register
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] rdy;
	logic [NUM_STAGES-1:0] vld_in;
	logic [NUM_STAGES-1:0] step;

	// filter state
	sample_t  lp_x_q [LP_TAPS];
	lp_acc_t  lp_y1_q;
	lp_acc_t  lp_y2_q;
	lp_t      hp_d_q [HP_TAPS];
	hp_sum_t  hp_sum_q;
	hp_t      slope_d_q [SLOPE_TAPS];
	sq_t      sq_line_q [WIN_LEN];
	win_sum_t win_sum_q;

	// pipeline payload
	sample_t  x_s1;
	lp_t      lp_s2;
	hp_t      hp_s3;
	hp_t      hp_s4;
	slope_t   slope_s4;
	hp_t      hp_s5;
	slope_t   slope_s5;
	sq_t      sq_s5;
	hp_t      hp_s6;
	slope_t   slope_s6;
	energy_t  energy_s6;

	// combinational results
	lp_acc_t    lp_acc;
	hp_sum_t    hp_sum_nxt;
	hp_t        hp_val;
	slope_raw_t slope_raw;
	logic signed [2*SLOPE_W-1:0] sq_full;
	win_sum_t   win_sum_nxt;

	always_comb begin
		rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign vld_in = {vld_q[NUM_STAGES-2:0], s_axis_tvalid};
	assign step   = rdy & vld_in;

	assign s_axis_tready = rdy[0];
	assign m_axis_tvalid = vld_q[NUM_STAGES-1];
	assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, energy_s6, slope_s6, hp_s6};

	// y = 2*y1 - y2 + x - 2*x[-6] + x[-12]; true value fits LP_ACC_W, so wraparound is exact
	assign lp_acc = (lp_y1_q <<< 1) - lp_y2_q + LP_ACC_W'(x_s1)
		- (LP_ACC_W'(lp_x_q[LP_MID-1]) <<< 1) + LP_ACC_W'(lp_x_q[LP_TAPS-1]);

	assign hp_sum_nxt = hp_sum_q + HP_SUM_W'(lp_s2) - HP_SUM_W'(hp_d_q[HP_TAPS-1]);
	assign hp_val     = HP_W'(hp_d_q[HP_LAG-1])
		- HP_W'($signed(hp_sum_nxt[HP_SUM_W-1:HP_SHIFT]));

	assign slope_raw = (SLOPE_RAW_W'(hp_s3) <<< 1) + SLOPE_RAW_W'(slope_d_q[0])
		- SLOPE_RAW_W'(slope_d_q[2]) - (SLOPE_RAW_W'(slope_d_q[3]) <<< 1);

	// |slope| stays below 3457, so the square fits SQ_W bits
	assign sq_full = slope_s4 * slope_s4;

	assign win_sum_nxt = win_sum_q - sq_line_q[WIN_LEN-1] + sq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	// recursive state advances only when a real transaction passes the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_x_q    <= '{default: '0};
			lp_y1_q   <= '0;
			lp_y2_q   <= '0;
			hp_d_q    <= '{default: '0};
			hp_sum_q  <= '0;
			slope_d_q <= '{default: '0};
			sq_line_q <= '{default: '0};
			win_sum_q <= '0;
		end else begin
			if (step[1]) begin
				lp_y2_q   <= lp_y1_q;
				lp_y1_q   <= lp_acc;
				lp_x_q[0] <= x_s1;
				for (int k = 1; k < LP_TAPS; k++) begin
					lp_x_q[k] <= lp_x_q[k-1];
				end
			end
			if (step[2]) begin
				hp_sum_q  <= hp_sum_nxt;
				hp_d_q[0] <= lp_s2;
				for (int k = 1; k < HP_TAPS; k++) begin
					hp_d_q[k] <= hp_d_q[k-1];
				end
			end
			if (step[3]) begin
				slope_d_q[0] <= hp_s3;
				for (int k = 1; k < SLOPE_TAPS; k++) begin
					slope_d_q[k] <= slope_d_q[k-1];
				end
			end
			if (step[5]) begin
				win_sum_q    <= win_sum_nxt;
				sq_line_q[0] <= sq_s5;
				for (int k = 1; k < WIN_LEN; k++) begin
					sq_line_q[k] <= sq_line_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step[0]) begin
			x_s1 <= sample_t'(s_axis_tdata[SAMPLE_W-1:0]);
		end
		if (step[1]) begin
			lp_s2 <= lp_acc[LP_ACC_W-1:LP_SHIFT];
		end
		if (step[2]) begin
			hp_s3 <= hp_val;
		end
		if (step[3]) begin
			hp_s4    <= hp_s3;
			slope_s4 <= slope_raw[SLOPE_RAW_W-1:SLOPE_SHIFT];
		end
		if (step[4]) begin
			hp_s5    <= hp_s4;
			slope_s5 <= slope_s4;
			sq_s5    <= sq_full[SQ_W-1:0];
		end
		if (step[5]) begin
			hp_s6     <= hp_s5;
			slope_s6  <= slope_s5;
			energy_s6 <= win_sum_nxt[WIN_SUM_W-1:WIN_SHIFT];
		end
	end

endmodule
